// ----- rtl/mpq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_pkg
// shared sizes, request and status codes and the cell command type for the
// max priority queue
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int SLOTS    = 16;
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 4;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(SLOTS + 1);

  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_EXTRACT = 2'd1;
  localparam logic [1:0] REQ_CHANGE  = 2'd2;
  localparam logic [1:0] REQ_REMOVE  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOHANDLE = 2'd3;

  typedef struct packed {
    logic shift;
    logic load_key;
    logic load_tag;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/max_priority_queue_with_handles.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// max_priority_queue_with_handles
// bounded max priority queue kept as an age-ordered chain of cells
// ----------------------------------------------------------------------------
// insert, change and remove: the request is registered, then the exec state
//   commits it once the response register is free; no new request is taken till then
// extract: exec answers an empty queue, else the max search walks the chain
//   one cell a cycle through a single comparator and the drop state answers
// reset clears the entry count and handle bits; cell contents need no reset
// ----------------------------------------------------------------------------
module max_priority_queue_with_handles
  import mpq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire logic [1:0]          req_type,
  input  wire logic [KEY_W-1:0]    key_value,
  input  wire logic [HANDLE_W-1:0] entry_handle,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output logic      [1:0]          status,
  output logic      [KEY_W-1:0]    result_key,
  output logic      [HANDLE_W-1:0] result_handle,
  output logic                     now_empty
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DROP = 2'd3;

  logic [1:0]          state, state_next;
  logic [1:0]          cur_type;
  logic [KEY_W-1:0]    cur_key;
  logic [HANDLE_W-1:0] cur_handle;
  logic [CNT_W-1:0]    count, count_next;
  logic [SLOTS-1:0]    busy, busy_next;
  logic [IDX_W-1:0]    ptr, ptr_next;
  logic                first, first_next;
  logic [KEY_W-1:0]    best_key, best_key_next;
  logic [HANDLE_W-1:0] best_tag, best_tag_next;
  logic [IDX_W-1:0]    best_pos, best_pos_next;

  cell_cmd_t           cmd [SLOTS];
  logic [KEY_W-1:0]    ckey [SLOTS];
  logic [HANDLE_W-1:0] ctag [SLOTS];
  logic [SLOTS-1:0]    chit;

  logic                out_free;
  logic                emit;
  logic [1:0]          e_status;
  logic [KEY_W-1:0]    e_key;
  logic [HANDLE_W-1:0] e_handle;

  logic [HANDLE_W-1:0] free_h;
  logic                has_free;
  logic [SLOTS-1:0]    live_hit;
  logic [IDX_W-1:0]    hit_pos;
  logic                handle_ok;
  logic [CNT_W-1:0]    cnt_dec;
  logic                drop_en;
  logic [IDX_W-1:0]    drop_pos;
  logic                ins_en;
  logic                chg_en;
  logic [KEY_W-1:0]    scan_key;
  logic [HANDLE_W-1:0] scan_tag;

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      logic [KEY_W-1:0]    nbk;
      logic [HANDLE_W-1:0] nbt;
      if (g == SLOTS - 1) begin : g_top
        assign nbk = '0;
        assign nbt = '0;
      end else begin : g_mid
        assign nbk = ckey[g+1];
        assign nbt = ctag[g+1];
      end
      mpq_cell u_cell (
        .clk    (clk),
        .cmd    (cmd[g]),
        .wr_key (cur_key),
        .wr_tag (free_h),
        .nb_key (nbk),
        .nb_tag (nbt),
        .probe  (cur_handle),
        .key    (ckey[g]),
        .tag    (ctag[g]),
        .hit    (chit[g])
      );
    end
  endgenerate

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);
  assign cnt_dec   = count - CNT_W'(1);
  assign scan_key  = ckey[ptr];
  assign scan_tag  = ctag[ptr];

  // lowest free handle
  always_comb begin
    free_h   = '0;
    has_free = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_h   = HANDLE_W'(i);
        has_free = 1'b1;
      end
    end
  end

  // live tags are unique, so the match position is an or of indices
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < SLOTS; i++) begin
      live_hit[i] = chit[i] && (CNT_W'(i) < count);
      if (live_hit[i]) begin
        hit_pos = hit_pos | IDX_W'(i);
      end
    end
  end

  assign handle_ok = busy[cur_handle] && (|live_hit);

  always_comb begin
    state_next    = state;
    ptr_next      = ptr;
    first_next    = first;
    best_key_next = best_key;
    best_tag_next = best_tag;
    best_pos_next = best_pos;
    emit          = 1'b0;
    e_status      = ST_OK;
    e_key         = '0;
    e_handle      = '0;
    drop_en       = 1'b0;
    drop_pos      = hit_pos;
    ins_en        = 1'b0;
    chg_en        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (cur_type)
          REQ_INSERT: begin
            if (out_free) begin
              emit       = 1'b1;
              state_next = S_IDLE;
              if (count == CNT_W'(SLOTS) || !has_free) begin
                e_status = ST_FULL;
              end else begin
                ins_en   = 1'b1;
                e_handle = free_h;
              end
            end
          end
          REQ_EXTRACT: begin
            if (count == '0) begin
              if (out_free) begin
                emit       = 1'b1;
                e_status   = ST_EMPTY;
                state_next = S_IDLE;
              end
            end else begin
              ptr_next   = cnt_dec[IDX_W-1:0];
              first_next = 1'b1;
              state_next = S_SCAN;
            end
          end
          default: begin
            if (out_free) begin
              emit       = 1'b1;
              state_next = S_IDLE;
              if (!handle_ok) begin
                e_status = ST_NOHANDLE;
              end else if (cur_type == REQ_CHANGE) begin
                chg_en = 1'b1;
              end else begin
                drop_en = 1'b1;
              end
            end
          end
        endcase
      end
      S_SCAN: begin
        first_next = 1'b0;
        if (first || scan_key > best_key) begin
          best_key_next = scan_key;
          best_tag_next = scan_tag;
          best_pos_next = ptr;
        end
        if (ptr == '0) begin
          state_next = S_DROP;
        end else begin
          ptr_next = ptr - IDX_W'(1);
        end
      end
      S_DROP: begin
        drop_pos = best_pos;
        if (out_free) begin
          emit       = 1'b1;
          e_key      = best_key;
          e_handle   = best_tag;
          drop_en    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // cell commands and bookkeeping
  always_comb begin
    count_next = count;
    busy_next  = busy;
    for (int i = 0; i < SLOTS; i++) begin
      cmd[i] = '0;
      if (ins_en && CNT_W'(i) == count) begin
        cmd[i].load_key = 1'b1;
        cmd[i].load_tag = 1'b1;
      end
      if (chg_en && IDX_W'(i) == hit_pos) begin
        cmd[i].load_key = 1'b1;
      end
      if (drop_en && IDX_W'(i) >= drop_pos && CNT_W'(i + 1) < count) begin
        cmd[i].shift = 1'b1;
      end
    end
    if (ins_en) begin
      count_next        = count + CNT_W'(1);
      busy_next[free_h] = 1'b1;
    end
    if (drop_en) begin
      count_next = cnt_dec;
      if (state == S_DROP) begin
        busy_next[best_tag] = 1'b0;
      end else begin
        busy_next[cur_handle] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      busy      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      busy  <= busy_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cur_type   <= req_type;
      cur_key    <= key_value;
      cur_handle <= entry_handle;
    end
    ptr      <= ptr_next;
    first    <= first_next;
    best_key <= best_key_next;
    best_tag <= best_tag_next;
    best_pos <= best_pos_next;
    if (emit) begin
      status        <= e_status;
      result_key    <= e_key;
      result_handle <= e_handle;
      now_empty     <= (count_next == '0);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SLOTS))
    else $error("entry count beyond slot total");

  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    $countones(busy) == int'(count))
    else $error("busy handles disagree with entry count");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (now_empty == (count == '0)))
    else $error("empty flag disagrees with entry count");

  a_scan_after_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (count != '0))
    else $error("max search on an empty queue");
`endif

endmodule
`default_nettype wire

// ----- rtl/mpq_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_cell
// one slot of the queue: holds a key and its handle, takes its upper
// neighbour's contents on a shift and flags a handle match
// ----------------------------------------------------------------------------
module mpq_cell
  import mpq_pkg::*;
(
  input  wire logic                clk,
  input  wire cell_cmd_t           cmd,
  input  wire logic [KEY_W-1:0]    wr_key,
  input  wire logic [HANDLE_W-1:0] wr_tag,
  input  wire logic [KEY_W-1:0]    nb_key,
  input  wire logic [HANDLE_W-1:0] nb_tag,
  input  wire logic [HANDLE_W-1:0] probe,
  output logic      [KEY_W-1:0]    key,
  output logic      [HANDLE_W-1:0] tag,
  output logic                     hit
);

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      key <= nb_key;
      tag <= nb_tag;
    end else begin
      if (cmd.load_key) begin
        key <= wr_key;
      end
      if (cmd.load_tag) begin
        tag <= wr_tag;
      end
    end
  end

  assign hit = (tag == probe);

endmodule
`default_nettype wire

// ----- tb/mpq_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mpq_result_checker
// Watches the request and response channels of the priority queue. Every
// accepted request beat is run through a local copy of the entry list
// (age-ordered keys, handles and busy bits). The predicted response is queued
// and compared field by field with the next accepted response beat.
// ----------------------------------------------------------------------------
module mpq_result_checker
  import mpq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  input  wire logic                req_ready,
  input  wire logic [1:0]          req_type,
  input  wire logic [KEY_W-1:0]    key_value,
  input  wire logic [HANDLE_W-1:0] entry_handle,
  input  wire logic                rsp_valid,
  input  wire logic                rsp_ready,
  input  wire logic [1:0]          status,
  input  wire logic [KEY_W-1:0]    result_key,
  input  wire logic [HANDLE_W-1:0] result_handle,
  input  wire logic                now_empty,
  output int                       outstanding,
  output int                       errors,
  output int                       checked
);

  typedef struct packed {
    logic [1:0]          status;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic                empty;
  } queue_result_t;

  logic [KEY_W-1:0]    live_keys[$];
  logic [HANDLE_W-1:0] live_handles[$];
  logic [SLOTS-1:0]    busy_mask = '0;
  queue_result_t       pending_results[$];

  function automatic queue_result_t serve_request(input logic [1:0] kind,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [HANDLE_W-1:0] h);
    queue_result_t r;
    int free_h;
    int best;
    int pos;
    r = '0;
    case (kind)
      REQ_INSERT: begin
        free_h = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!busy_mask[i]) free_h = i;
        if (live_keys.size() >= SLOTS || free_h < 0) begin
          r.status = ST_FULL;
        end else begin
          busy_mask[free_h] = 1'b1;
          live_keys.push_back(key);
          live_handles.push_back(HANDLE_W'(free_h));
          r.status = ST_OK;
          r.handle = HANDLE_W'(free_h);
        end
      end
      REQ_EXTRACT: begin
        if (live_keys.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // newest first, strict compare so the newest of equal keys wins
          best = live_keys.size() - 1;
          for (int i = live_keys.size() - 2; i >= 0; i--)
            if (live_keys[i] > live_keys[best]) best = i;
          r.status = ST_OK;
          r.key    = live_keys[best];
          r.handle = live_handles[best];
          busy_mask[live_handles[best]] = 1'b0;
          live_keys.delete(best);
          live_handles.delete(best);
        end
      end
      default: begin
        pos = -1;
        if (h < SLOTS && busy_mask[h])
          for (int i = 0; i < live_handles.size(); i++)
            if (pos < 0 && live_handles[i] == h) pos = i;
        if (pos < 0) begin
          r.status = ST_NOHANDLE;
        end else if (kind == REQ_CHANGE) begin
          r.status = ST_OK;
          live_keys[pos] = key;
        end else begin
          r.status = ST_OK;
          busy_mask[h] = 1'b0;
          live_keys.delete(pos);
          live_handles.delete(pos);
        end
      end
    endcase
    r.empty = (live_keys.size() == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] wanted);
    errors++;
    if (errors <= 200)
      $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, seen, wanted);
  endtask

  always @(posedge clk) begin : watch
    queue_result_t want;
    if (rst) begin
      live_keys.delete();
      live_handles.delete();
      pending_results.delete();
      busy_mask = '0;
      outstanding <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        checked++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected response beat",
                          64'({status, result_handle}), 64'(0));
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status)
            report_mismatch("status", 64'(status), 64'(want.status));
          if (result_key !== want.key)
            report_mismatch("result_key", 64'(result_key), 64'(want.key));
          if (result_handle !== want.handle)
            report_mismatch("result_handle", 64'(result_handle), 64'(want.handle));
          if (now_empty !== want.empty)
            report_mismatch("now_empty", 64'(now_empty), 64'(want.empty));
        end
      end
      if (req_valid && req_ready)
        pending_results.push_back(serve_request(req_type, key_value, entry_handle));
      outstanding <= pending_results.size();
    end
  end

endmodule

// ----- tb/tb_max_priority_queue_with_handles.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_max_priority_queue_with_handles
// Drives request beats into the priority queue: a directed opening (empty
// extract, unknown handles, filling to full, extreme and tied keys) and then
// phases of random traffic that lean towards filling, draining or handle
// operations. Both channels idle at random; the checker does all predicting.
// ----------------------------------------------------------------------------
module tb_max_priority_queue_with_handles;
  import mpq_pkg::*;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                req_valid    = 1'b0;
  logic [1:0]          req_type     = REQ_INSERT;
  logic [KEY_W-1:0]    key_value    = '0;
  logic [HANDLE_W-1:0] entry_handle = '0;
  logic                rsp_ready    = 1'b0;
  wire                 req_ready;
  wire                 rsp_valid;
  wire  [1:0]          status;
  wire  [KEY_W-1:0]    result_key;
  wire  [HANDLE_W-1:0] result_handle;
  wire                 now_empty;

  int outstanding;
  int errors;
  int checked;
  bit calm = 1'b0;
  int stall_left = 0;
  int sent[4] = '{0, 0, 0, 0};

  max_priority_queue_with_handles dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req_type      (req_type),
    .key_value     (key_value),
    .entry_handle  (entry_handle),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .status        (status),
    .result_key    (result_key),
    .result_handle (result_handle),
    .now_empty     (now_empty)
  );

  mpq_result_checker result_check (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req_type      (req_type),
    .key_value     (key_value),
    .entry_handle  (entry_handle),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .status        (status),
    .result_key    (result_key),
    .result_handle (result_handle),
    .now_empty     (now_empty),
    .outstanding   (outstanding),
    .errors        (errors),
    .checked       (checked)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d results outstanding", outstanding);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 50) return KEY_W'($urandom_range(0, 7));
    return $urandom;
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_handle();
    if ($urandom_range(0, 99) < 70) return HANDLE_W'($urandom_range(0, 7));
    return HANDLE_W'($urandom_range(0, SLOTS - 1));
  endfunction

  task automatic issue(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                       input logic [HANDLE_W-1:0] h);
    int gap;
    req_valid    <= 1'b1;
    req_type     <= kind;
    key_value    <= key;
    entry_handle <= h;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent[kind]++;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // response side stalls
  always @(posedge clk) begin
    if (calm) begin
      rsp_ready <= 1'b1;
    end else if (stall_left > 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp_ready <= 1'b1;
      if ($urandom_range(0, 99) < 30) stall_left <= pick_gap();
    end
  end

  initial begin
    logic [KEY_W-1:0] first_keys[16];
    int               roll;
    int               mode;
    logic [1:0]       kind;
    first_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0007, 32'h0000_0007,
                   32'h0000_0007, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
                   32'h5A5A_A5A5, 32'hA5A5_5A5A, 32'h0000_0007, 32'hFFFF_FFFE,
                   32'h1234_5678, 32'hCAFE_0001, 32'h0F0F_F0F0, 32'h0000_0002};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue and unknown handles
    issue(REQ_EXTRACT, '1, 4'hF);
    issue(REQ_CHANGE, 32'h1234, 4'd5);
    issue(REQ_REMOVE, '0, 4'd15);
    // fill to the top, then one more
    for (int i = 0; i < SLOTS; i++) issue(REQ_INSERT, first_keys[i], 4'hA);
    issue(REQ_INSERT, '1, 4'h0);
    // tie on the largest key, newest entry should win
    issue(REQ_CHANGE, '1, 4'd2);
    issue(REQ_EXTRACT, '0, 4'h0);
    issue(REQ_REMOVE, '0, 4'd0);
    issue(REQ_REMOVE, '0, 4'd0);
    issue(REQ_EXTRACT, '0, 4'h0);
    settle();

    for (int blk = 0; blk < 9; blk++) begin
      calm = (blk == 2 || blk == 6);
      mode = blk % 4;
      repeat (100) begin
        roll = $urandom_range(0, 99);
        case (mode)
          0: kind = roll < 55 ? REQ_INSERT : roll < 70 ? REQ_EXTRACT :
                    roll < 85 ? REQ_CHANGE : REQ_REMOVE;
          1: kind = roll < 25 ? REQ_INSERT : roll < 70 ? REQ_EXTRACT :
                    roll < 85 ? REQ_CHANGE : REQ_REMOVE;
          2: kind = roll < 30 ? REQ_INSERT : roll < 55 ? REQ_EXTRACT :
                    roll < 80 ? REQ_CHANGE : REQ_REMOVE;
          default: kind = roll < 30 ? REQ_INSERT : roll < 40 ? REQ_EXTRACT :
                          roll < 70 ? REQ_CHANGE : REQ_REMOVE;
        endcase
        issue(kind, pick_key(), pick_handle());
      end
      settle();
    end
    calm = 1'b0;

    repeat (40) @(posedge clk);
    $display("requests sent: %0d insert, %0d extract, %0d change, %0d remove",
             sent[REQ_INSERT], sent[REQ_EXTRACT], sent[REQ_CHANGE], sent[REQ_REMOVE]);
    $display("responses compared: %0d, mismatches: %0d", checked, errors);
    if (errors == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
